@@ design/eabc_pkg.sv @@
// Package for the ECG averaging biquad chain.
// Holds the fixed output range and the section coefficient table; no dependencies.
package eabc_pkg;

    localparam int unsigned OUT_WIDTH = 12;
    localparam int unsigned SAMPLE_WIDTH = 12;
    localparam int unsigned NUM_SAMPLES = 8;
    localparam int unsigned NUM_SECTIONS = 3;
    localparam int unsigned TAPS = 5;
    localparam int unsigned OFFSET = 2048;
    localparam int unsigned OUT_MAX = 4095;

    typedef logic [SAMPLE_WIDTH-1:0] t_sample;

    // Coefficients times 10000: b0, b1, b2, a1, a2 per section.
    function automatic int coef_dec(input logic [1:0] sec, input logic [2:0] tap);
        int r;
        r = 0;
        unique case (sec)
            2'd0: begin
                unique case (tap)
                    3'd0: r = 9651;
                    3'd1: r = -2347;
                    3'd2: r = 9651;
                    3'd3: r = -2347;
                    3'd4: r = 9302;
                    default: r = 0;
                endcase
            end
            2'd1: begin
                unique case (tap)
                    3'd0: r = 2066;
                    3'd1: r = 4131;
                    3'd2: r = 2066;
                    3'd3: r = -3695;
                    3'd4: r = 1958;
                    default: r = 0;
                endcase
            end
            2'd2: begin
                unique case (tap)
                    3'd0: r = 9922;
                    3'd1: r = -19844;
                    3'd2: r = 9922;
                    3'd3: r = -19844;
                    3'd4: r = 9845;
                    default: r = 0;
                endcase
            end
            default: r = 0;
        endcase
        return r;
    endfunction

endpackage

@@ design/eabc_if.sv @@
// Valid/ready channel interfaces for the ECG chain.
// Depends on eabc_pkg for the sample type.
interface eabc_in_if;
    import eabc_pkg::*;
    logic    valid;
    logic    ready;
    logic    lead_plus_off;
    logic    lead_minus_off;
    t_sample sample_0, sample_1, sample_2, sample_3;
    t_sample sample_4, sample_5, sample_6, sample_7;
    modport source(output valid, lead_plus_off, lead_minus_off, sample_0, sample_1,
                   sample_2, sample_3, sample_4, sample_5, sample_6, sample_7,
                   input ready);
    modport sink(input valid, lead_plus_off, lead_minus_off, sample_0, sample_1,
                 sample_2, sample_3, sample_4, sample_5, sample_6, sample_7,
                 output ready);
endinterface

interface eabc_out_if;
    import eabc_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [OUT_WIDTH-1:0] ecg_value;
    logic                 lead_fault;
    modport source(output valid, ecg_value, lead_fault, input ready);
    modport sink(input valid, ecg_value, lead_fault, output ready);
endinterface

@@ design/ecg_average_biquad_chain.sv @@
// ECG averager and three-section biquad chain (notch, low-pass, high-pass).
// A leads-off item skips the arithmetic and goes straight to the output step. Other items pass
// through summing, serial division, loading the mean, 15 products computed one after another
// on one shift-and-add unit, and finish.
// One item at a time; a waiting result stalls only the final hand-over of the next item to
// the output register. Reset is synchronous, active low, and clears control and histories.
module ecg_average_biquad_chain #(
    parameter int SAMPLES_PER_TICK = 8,
    parameter int FRACTION_BITS = 16,
    parameter int HISTORY_WIDTH = 40
) (
    input  logic i_clk,
    input  logic i_rst_n,
    eabc_in_if.sink    i_in,
    eabc_out_if.source o_out
);
    import eabc_pkg::*;

    localparam int HW = HISTORY_WIDTH;
    localparam int CW = FRACTION_BITS + 3;        // coefficient: Q2.F plus sign
    localparam int PW = HW + CW;                  // full product width
    localparam int AW = HW + 4;                   // accumulator holds five terms
    localparam int TW = HW + 8;                   // offset and clamp stage
    localparam int SCW = $clog2(NUM_SAMPLES + 1);
    localparam int BCW = $clog2(HW + 1);
    localparam int SUMW = SAMPLE_WIDTH + 3;
    localparam int MEANW = SAMPLE_WIDTH;
    localparam int RW = 4;                        // divider partial remainder
    localparam logic signed [TW-1:0] TOP_OFF = TW'(OFFSET) << FRACTION_BITS;
    localparam logic signed [TW-1:0] TOP_MAX = TW'(OUT_MAX) << FRACTION_BITS;

    typedef enum logic [3:0] {
        S_IDLE, S_SUM, S_DIV, S_LOAD, S_MUL, S_ACC, S_NEXT, S_FIN, S_OUT
    } t_state;

    // Quantized coefficient, rounded to nearest with ties away from zero.
    function automatic logic signed [CW-1:0] quant(input logic [1:0] sec,
                                                   input logic [2:0] tap);
        longint d;
        longint m;
        longint q;
        d = longint'(coef_dec(sec, tap));
        m = (d < 0) ? -d : d;
        q = ((m <<< FRACTION_BITS) + 64'sd5000) / 64'sd10000;
        return (d < 0) ? CW'(-q) : CW'(q);
    endfunction

    function automatic logic signed [HW-1:0] sat(input logic signed [AW-1:0] v);
        logic signed [AW-1:0] hi;
        logic signed [AW-1:0] lo;
        hi = AW'({1'b0, {(HW-1){1'b1}}});
        lo = -hi - AW'(1);
        if (v > hi) return hi[HW-1:0];
        if (v < lo) return lo[HW-1:0];
        return v[HW-1:0];
    endfunction

    // Scales the mean to the history format and limits it to the positive range.
    function automatic logic signed [HW-1:0] sat_mean(input logic [MEANW-1:0] q);
        logic [MEANW+FRACTION_BITS-1:0] w;
        logic [MEANW+FRACTION_BITS-1:0] hi;
        w = {q, {FRACTION_BITS{1'b0}}};
        hi = (MEANW+FRACTION_BITS)'({(HW-1){1'b1}});
        if (w > hi) return {1'b0, {(HW-1){1'b1}}};
        return HW'(w);
    endfunction

    t_state r_state;
    logic signed [HW-1:0] r_hist [NUM_SECTIONS][4];
    t_sample r_smp [NUM_SAMPLES];
    logic [SCW-1:0] r_scnt;
    logic [SUMW-1:0] r_sum;
    logic [RW-2:0] r_rem;
    logic [1:0] r_sec;
    logic [2:0] r_tap;
    logic signed [HW-1:0] r_x;           // section input
    logic signed [HW-1:0] r_mcand;       // shifting multiplicand (serial operand)
    logic signed [PW-1:0] r_prod;
    logic signed [PW-1:0] r_addend;      // coefficient, shifted left each cycle
    logic [BCW-1:0] r_bcnt;
    logic signed [AW-1:0] r_acc;
    logic [OUT_WIDTH-1:0] r_rval;        // finished result, waiting for the output register
    logic r_roff;
    logic r_ovalid;
    logic [OUT_WIDTH-1:0] r_oval;
    logic r_ooff;

    logic signed [CW-1:0] w_coef_tab [NUM_SECTIONS][TAPS];
    logic signed [HW-1:0] w_oper;
    logic signed [CW-1:0] w_coef;
    logic signed [PW-1:0] w_rnd;
    logic signed [AW-1:0] w_term;
    logic signed [HW-1:0] w_ys;
    logic signed [TW-1:0] w_top;
    logic [SUMW-1:0] w_add;
    logic [RW-1:0] w_rsh;

    // The coefficient table is fixed at elaboration.
    for (genvar gs = 0; gs < NUM_SECTIONS; gs++) begin : g_sec
        for (genvar gt = 0; gt < TAPS; gt++) begin : g_tap
            localparam logic signed [CW-1:0] C_Q = quant(2'(gs), 3'(gt));
            assign w_coef_tab[gs][gt] = C_Q;
        end
    end

    assign i_in.ready = (r_state == S_IDLE);
    assign o_out.valid = r_ovalid;
    assign o_out.ecg_value = r_oval;
    assign o_out.lead_fault = r_ooff;

    always_comb begin
        unique case (r_tap)
            3'd0: w_oper = r_x;
            3'd1: w_oper = r_hist[r_sec][0];
            3'd2: w_oper = r_hist[r_sec][1];
            3'd3: w_oper = r_hist[r_sec][2];
            default: w_oper = r_hist[r_sec][3];
        endcase
        // The mean-loaded mark selects the first tap.
        w_coef = w_coef_tab[r_sec][(r_tap == 3'd7) ? 3'd0 : r_tap];
        // Product rounded to nearest, ties toward plus infinity.
        w_rnd = (r_prod + (PW'(1) <<< (FRACTION_BITS - 1))) >>> FRACTION_BITS;
        w_term = AW'(w_rnd);
        w_ys = sat(r_acc);
        w_top = TW'(r_x) + TOP_OFF;
        w_add = (r_scnt < SCW'(SAMPLES_PER_TICK)) ? SUMW'(r_smp[0]) : '0;
        w_rsh = {r_rem, r_sum[SUMW-1]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ovalid <= 1'b0;
            for (int s = 0; s < NUM_SECTIONS; s++)
                for (int k = 0; k < 4; k++)
                    r_hist[s][k] <= '0;
        end else begin
            if (r_state == S_OUT && (!r_ovalid || o_out.ready)) r_ovalid <= 1'b1;
            else if (r_ovalid && o_out.ready) r_ovalid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_in.valid && i_in.ready) begin
                        if (i_in.lead_plus_off || i_in.lead_minus_off) begin
                            r_rval <= '0;
                            r_roff <= 1'b1;
                            r_state <= S_OUT;
                        end else begin
                            r_smp[0] <= i_in.sample_0; r_smp[1] <= i_in.sample_1;
                            r_smp[2] <= i_in.sample_2; r_smp[3] <= i_in.sample_3;
                            r_smp[4] <= i_in.sample_4; r_smp[5] <= i_in.sample_5;
                            r_smp[6] <= i_in.sample_6; r_smp[7] <= i_in.sample_7;
                            r_scnt <= '0;
                            r_sum <= '0;
                            r_state <= S_SUM;
                        end
                    end
                end
                S_SUM: begin
                    // Samples shift past one adder, one per cycle.
                    r_sum <= r_sum + w_add;
                    for (int k = 0; k < NUM_SAMPLES - 1; k++) r_smp[k] <= r_smp[k+1];
                    r_scnt <= r_scnt + SCW'(1);
                    if (r_scnt == SCW'(NUM_SAMPLES - 1)) begin
                        r_rem <= '0;
                        r_bcnt <= '0;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    // Restoring division, one quotient bit per cycle; the quotient
                    // shifts into the sum register from the bottom.
                    if (w_rsh >= RW'(SAMPLES_PER_TICK)) begin
                        r_rem <= (RW-1)'(w_rsh - RW'(SAMPLES_PER_TICK));
                        r_sum <= {r_sum[SUMW-2:0], 1'b1};
                    end else begin
                        r_rem <= (RW-1)'(w_rsh);
                        r_sum <= {r_sum[SUMW-2:0], 1'b0};
                    end
                    r_bcnt <= r_bcnt + BCW'(1);
                    if (r_bcnt == BCW'(SUMW - 1)) begin
                        r_state <= S_LOAD;
                        r_sec <= 2'd0;
                        r_tap <= 3'd0;
                        r_acc <= '0;
                    end
                end
                S_LOAD: begin
                    if (r_sec == 2'd0 && r_tap == 3'd0) begin
                        r_x <= sat_mean(r_sum[MEANW-1:0]);
                        r_state <= S_LOAD;
                        r_tap <= 3'd7;     // marks mean already loaded
                    end else begin
                        if (r_tap == 3'd7) r_tap <= 3'd0;
                        r_mcand <= (r_tap == 3'd7) ? r_x : w_oper;
                        r_addend <= PW'(w_coef);
                        r_prod <= '0;
                        r_bcnt <= '0;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    // One operand bit per cycle; the top bit carries negative weight.
                    if (r_bcnt == BCW'(HW - 1)) begin
                        if (r_mcand[0]) r_prod <= r_prod - r_addend;
                        r_state <= S_ACC;
                    end else if (r_mcand[0]) begin
                        r_prod <= r_prod + r_addend;
                    end
                    r_mcand <= r_mcand >>> 1;
                    r_addend <= r_addend <<< 1;
                    r_bcnt <= r_bcnt + BCW'(1);
                end
                S_ACC: begin
                    if (r_tap >= 3'd3) r_acc <= r_acc - w_term;
                    else r_acc <= r_acc + w_term;
                    r_state <= S_NEXT;
                end
                S_NEXT: begin
                    if (r_tap == 3'd4) begin
                        r_hist[r_sec][1] <= r_hist[r_sec][0];
                        r_hist[r_sec][0] <= r_x;
                        r_hist[r_sec][3] <= r_hist[r_sec][2];
                        r_hist[r_sec][2] <= w_ys;
                        r_x <= w_ys;
                        r_acc <= '0;
                        r_tap <= 3'd0;
                        if (r_sec == 2'(NUM_SECTIONS - 1)) begin
                            r_state <= S_FIN;
                        end else begin
                            r_sec <= r_sec + 2'd1;
                            r_state <= S_LOAD;
                        end
                    end else begin
                        r_tap <= r_tap + 3'd1;
                        r_state <= S_LOAD;
                    end
                end
                S_FIN: begin
                    // The last section output sits in r_x.
                    r_roff <= 1'b0;
                    if (w_top < 0) r_rval <= '0;
                    else if (w_top > TOP_MAX) r_rval <= OUT_WIDTH'(OUT_MAX);
                    else r_rval <= w_top[FRACTION_BITS +: OUT_WIDTH];
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!r_ovalid || o_out.ready) begin
                        r_oval <= r_rval;
                        r_ooff <= r_roff;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

@@ design/eabc_checker.sv @@
// Port-level checker for the ECG chain, bound to the top level.
// Depends on the channel interfaces and the top level's ports.
module eabc_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic i_in_ready,
    input logic i_lp,
    input logic i_lm,
    input logic i_out_valid,
    input logic i_out_ready,
    input logic [11:0] i_val,
    input logic i_off
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_val) && $stable(i_off))
        else $error("stalled result changed");
    a_off_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_off |-> i_val == 12'd0)
        else $error("leads-off item gave nonzero value");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("accepted a second item while busy");
    a_offres: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && (i_lp || i_lm) && !i_out_valid |=> ##1 i_out_valid && i_off)
        else $error("leads-off result missing");
endmodule

bind ecg_average_biquad_chain eabc_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .i_in_valid(i_in.valid), .i_in_ready(i_in.ready),
    .i_lp(i_in.lead_plus_off), .i_lm(i_in.lead_minus_off),
    .i_out_valid(o_out.valid), .i_out_ready(o_out.ready),
    .i_val(o_out.ecg_value), .i_off(o_out.lead_fault)
);
